// ===== rtl/load_cell_weight_filter_defines.svh =====
// Assertion macros shared by the load cell weight filter RTL.
`ifndef LOAD_CELL_WEIGHT_FILTER_DEFINES_SVH
`define LOAD_CELL_WEIGHT_FILTER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LCWF_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define LCWF_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/lcwf_pkg.sv =====
// Shared types and constants of the load cell weight filter.
package lcwf_pkg;

   localparam logic signed [23:0] RAW_SENTINEL = 24'sh800000;
   localparam logic [31:0] MIN_GAP_MS = 32'd60000;
   localparam logic [2:0] MED_SIZE = 3'd5;
   localparam logic [2:0] MED_LAST = 3'd4;
   localparam logic [2:0] MED_RANK = 3'd2;

   typedef enum logic [2:0] {
      ST_CLOSED   = 3'd0,
      ST_SENTINEL = 3'd1,
      ST_GLITCH   = 3'd2,
      ST_FILLING  = 3'd3,
      ST_UNSTABLE = 3'd4,
      ST_HOLDING  = 3'd5,
      ST_LATCHED  = 3'd6
   } status_type;

   typedef enum logic [3:0] {
      REG_RAW_OFFSET   = 4'd0,
      REG_SCALE        = 4'd1,
      REG_GLITCH_JUMP  = 4'd2,
      REG_STABLE_BAND  = 4'd3,
      REG_STABLE_HOLD  = 4'd4,
      REG_TARE         = 4'd5,
      REG_TOLERANCE    = 4'd6,
      REG_WINDOW_IVL   = 4'd7
   } reg_index_type;

   typedef enum logic [3:0] {
      S_IDLE, S_FRONT, S_MED, S_MAG, S_MUL0, S_MUL1, S_CONV,
      S_WALK, S_DIV, S_FIN, S_OUT
   } state_type;

   typedef struct packed {
      logic req_fire;
      logic front_fin;
      logic med_last;
      logic walk_done;
      logic div_done;
      logic out_free;
   } lcwf_ev_type;

   typedef struct packed {
      state_type state;
      logic      req_ready;
      logic      div_start;
      logic      out_load;
   } lcwf_ctl_type;

endpackage

// ===== rtl/lcwf_div.sv =====
// Restoring divider, one quotient bit per cycle.
module lcwf_div #(
   parameter int NW = 38,
   parameter int DW = 7
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          done,
   output logic [NW-1:0] quo
);
   localparam int CW = $clog2(NW + 1);

   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic          done_ff;
   logic [NW-1:0] quo_ff;
   logic [DW-1:0] rem_ff;
   logic [DW-1:0] den_ff;
   logic [DW:0]   rem_sh;
   logic [DW:0]   rem_sub;
   logic          fits;

   // Shift in the next dividend bit and try the subtract
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[NW-1]};
      rem_sub = rem_sh - {1'b0, den_ff};
      fits    = rem_sh >= {1'b0, den_ff};
   end

   // Control: count steps, pulse done after the last one
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(NW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[NW-2:0], fits};
         rem_ff <= fits ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;
endmodule

// ===== rtl/lcwf_ctrl.sv =====
// Sequencer that steps one item through the shared datapath.
module lcwf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  lcwf_pkg::lcwf_ev_type ev,
   output lcwf_pkg::lcwf_ctl_type ctl
);
   import lcwf_pkg::*;

   state_type state_ff;
   state_type state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (ev.req_fire) state_in = S_FRONT;
         S_FRONT: state_in = ev.front_fin ? S_OUT : S_MED;
         S_MED:   if (ev.med_last) state_in = S_MAG;
         S_MAG:   state_in = S_MUL0;
         S_MUL0:  state_in = S_MUL1;
         S_MUL1:  state_in = S_CONV;
         S_CONV:  state_in = S_WALK;
         S_WALK:  if (ev.walk_done) state_in = S_DIV;
         S_DIV:   if (ev.div_done) state_in = S_FIN;
         S_FIN:   state_in = S_OUT;
         S_OUT:   if (ev.out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Outputs
   always_comb begin
      ctl.state     = state_ff;
      ctl.req_ready = 1'b0;
      ctl.div_start = 1'b0;
      ctl.out_load  = 1'b0;
      case (state_ff)
         S_IDLE:  ctl.req_ready = 1'b1;
         S_WALK:  ctl.div_start = ev.walk_done;
         S_OUT:   ctl.out_load = ev.out_free;
         default: ctl.req_ready = 1'b0;
      endcase
   end
endmodule

// ===== rtl/load_cell_weight_filter.sv =====
// Top level of the load cell weight filter: datapath, state and ports.
//
// Usage: each req item carries one signed 24-bit converter sample and a
// millisecond timestamp; each accepted item produces exactly one rsp item with
// the status code (tuser), the latched stable weight in milligrams, the
// has-stable flag and the window-open flag (tdata). The csr port writes the
// eight setup registers with no wait; write them only while the block is idle.
// Items that end early (window closed, sentinel, glitch, median still filling)
// skip from the front step straight to the output step. Full items take 5
// median rank steps, 2 passes of a 25x16 multiplier, one averaging-memory
// read per filled entry, and one quotient bit per cycle in the shared divider.
// One item is in work at a time; req_tready is high only while the sequencer
// is idle, in the cycle after the result is loaded, so a new item is taken
// only after the previous one has been loaded. The result sits in an output
// register, so the next item is accepted while it waits; a stalled receiver
// holds rsp stable and only blocks the following result. Reset empties all
// filters, forgets the stable weight, restores the register defaults and opens
// the window.
module load_cell_weight_filter #(
   parameter int AVERAGE_DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: raw_sample [23:0], now_ms [55:24]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,
   // rsp_tdata: stable_weight_mg [31:0], has_stable [32], window_open [33]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   // rsp_tuser: status [2:0]
   output logic [2:0]  rsp_tuser,
   input  logic        csr_we,
   input  logic [3:0]  csr_addr,
   input  logic [31:0] csr_wdata
);
   import lcwf_pkg::*;

   localparam int AW = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
   localparam int FW = $clog2(AVERAGE_DEPTH + 1);
   localparam int SW = 32 + FW;

   lcwf_ev_type  ev;
   lcwf_ctl_type ctl;

   // Setup registers
   logic signed [23:0] off_ff;
   logic [31:0]        scale_ff;
   logic [23:0]        gj_ff;
   logic [30:0]        band_ff;
   logic [31:0]        hold_ff;
   logic signed [31:0] tare_ff;
   logic [30:0]        tol_ff;
   logic [31:0]        ivl_ff;

   // Filter state
   logic signed [23:0] raw_ff;
   logic [31:0]        now_ff;
   logic signed [23:0] prev_ff;
   logic               prev_vld_ff;
   logic signed [23:0] med_ff [5];
   logic [2:0]         mpos_ff;
   logic [2:0]         mfill_ff;
   logic [AW-1:0]      apos_ff;
   logic [FW-1:0]      afill_ff;
   logic [31:0]        st_start_ff;
   logic               timing_ff;
   logic signed [31:0] latch_ff;
   logic               latch_vld_ff;
   logic               win_ff;
   logic [31:0]        next_ms_ff;
   logic               next_set_ff;
   status_type         status_ff;

   // Work registers
   logic [2:0]         cand_ff;
   logic signed [23:0] median_ff;
   logic               cneg_ff;
   logic [24:0]        cmag_ff;
   logic [56:0]        pacc_ff;
   logic [FW-1:0]      iss_ff;
   logic               rdv_ff;
   logic               first_ff;
   logic signed [SW-1:0] sum_ff;
   logic signed [31:0] mn_ff;
   logic signed [31:0] mx_ff;
   logic signed [31:0] rd_ff;
   logic signed [31:0] avg_mem [AVERAGE_DEPTH];

   // Output register
   logic               rsp_vld_ff;
   status_type         rsp_status_ff;
   logic [31:0]        rsp_weight_ff;
   logic               rsp_has_ff;
   logic               rsp_win_ff;

   // Front-end decisions
   logic               interval;
   logic [31:0]        open_diff;
   logic               closed;
   logic               reopen;
   logic               sentinel;
   logic signed [24:0] raw_d;
   logic [24:0]        raw_dmag;
   logic               glitch;
   logic [2:0]         mpos_eff;
   logic [2:0]         mfill_eff;
   logic [2:0]         mfill_new;

   always_comb begin
      interval  = ivl_ff != 32'd0;
      open_diff = now_ff - next_ms_ff;
      closed    = interval && !win_ff && next_set_ff && open_diff[31];
      reopen    = interval && !win_ff && !closed;
      sentinel  = raw_ff == RAW_SENTINEL;
      raw_d     = {raw_ff[23], raw_ff} - {prev_ff[23], prev_ff};
      raw_dmag  = raw_d[24] ? 25'(-raw_d) : 25'(raw_d);
      glitch    = prev_vld_ff && (raw_dmag > {1'b0, gj_ff});
      mpos_eff  = reopen ? 3'd0 : mpos_ff;
      mfill_eff = reopen ? 3'd0 : mfill_ff;
      mfill_new = (mfill_eff < MED_SIZE) ? mfill_eff + 3'd1 : mfill_eff;
   end

   // Median rank test of one candidate against all five entries
   logic signed [23:0] cand_v;
   logic [2:0]         lt_cnt;
   logic [2:0]         le_cnt;
   logic               is_med;

   always_comb begin
      cand_v = med_ff[cand_ff];
      lt_cnt = 3'd0;
      le_cnt = 3'd0;
      for (int j = 0; j < 5; j++) begin
         if (med_ff[j] < cand_v) lt_cnt = lt_cnt + 3'd1;
         if (med_ff[j] <= cand_v) le_cnt = le_cnt + 3'd1;
      end
      is_med = (lt_cnt <= MED_RANK) && (le_cnt > MED_RANK);
   end

   // Shared multiplier: one 16-bit half of the scale per pass
   logic signed [24:0] dconv;
   logic [15:0]        mul_b;
   logic [40:0]        prod;

   always_comb begin
      dconv = {median_ff[23], median_ff} - {off_ff[23], off_ff};
      mul_b = (ctl.state == S_MUL0) ? scale_ff[15:0] : scale_ff[31:16];
      prod  = cmag_ff * mul_b;
   end

   // Round to nearest, ties away from zero, then saturate
   logic [56:0]        pround;
   logic [40:0]        rq;
   logic signed [31:0] mg_w;

   always_comb begin
      pround = pacc_ff + 57'd32768;
      rq     = pround[56:16];
      if (!cneg_ff) begin
         mg_w = (rq > 41'h07FFFFFFF) ? 32'sh7FFFFFFF : $signed(rq[31:0]);
      end else begin
         mg_w = (rq > 41'h080000000) ? 32'sh80000000 : $signed(~rq[31:0] + 32'd1);
      end
   end

   // Walk over the filled entries of the averaging memory
   logic               issue;
   logic               walk_done;
   logic [SW-1:0]      smag;
   logic [SW-1:0]      div_num;
   logic [SW-1:0]      quo;
   logic               div_done;

   always_comb begin
      issue     = iss_ff < afill_ff;
      walk_done = !issue && !rdv_ff;
      smag      = sum_ff[SW-1] ? SW'(-sum_ff) : SW'(sum_ff);
      div_num   = smag + SW'(afill_ff >> 1);
   end

   lcwf_div #(
      .NW(SW),
      .DW(FW)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(ctl.div_start),
      .num  (div_num),
      .den  (afill_ff),
      .done (div_done),
      .quo  (quo)
   );

   // Stability decision
   logic signed [33:0] avg_w;
   logic signed [33:0] fin_d;
   logic signed [31:0] fin_w;
   logic signed [32:0] span;
   logic               stable;
   logic [31:0]        start_eff;
   logic [31:0]        held_ms;
   logic               held;
   logic signed [32:0] dv;
   logic [32:0]        dvmag;
   logic               change;
   logic [31:0]        gap;

   always_comb begin
      avg_w     = sum_ff[SW-1] ? -$signed({1'b0, quo[32:0]}) : $signed({1'b0, quo[32:0]});
      fin_d     = avg_w - 34'(tare_ff);
      if (fin_d > 34'sh07FFFFFFF) begin
         fin_w = 32'sh7FFFFFFF;
      end else if (fin_d < -34'sh080000000) begin
         fin_w = 32'sh80000000;
      end else begin
         fin_w = fin_d[31:0];
      end
      span      = {mx_ff[31], mx_ff} - {mn_ff[31], mn_ff};
      stable    = span < $signed({2'b00, band_ff});
      start_eff = timing_ff ? st_start_ff : now_ff;
      held_ms   = now_ff - start_eff;
      held      = held_ms >= hold_ff;
      dv        = {fin_w[31], fin_w} - {latch_ff[31], latch_ff};
      dvmag     = dv[32] ? 33'(-dv) : 33'(dv);
      change    = !latch_vld_ff || (dvmag > {2'b00, tol_ff});
      gap       = (ivl_ff < MIN_GAP_MS) ? MIN_GAP_MS : ivl_ff;
   end

   // Sequencer events
   always_comb begin
      ev.req_fire  = req_tvalid && ctl.req_ready;
      ev.front_fin = closed || sentinel || glitch || (mfill_new < MED_SIZE);
      ev.med_last  = cand_ff == MED_LAST;
      ev.walk_done = walk_done;
      ev.div_done  = div_done;
      ev.out_free  = !rsp_vld_ff || rsp_tready;
   end

   lcwf_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .ev   (ev),
      .ctl  (ctl)
   );

   // Setup writes and filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff       <= '0;
         scale_ff     <= 32'd65536;
         gj_ff        <= 24'hFFFFFF;
         band_ff      <= 31'd50;
         hold_ff      <= '0;
         tare_ff      <= '0;
         tol_ff       <= '0;
         ivl_ff       <= '0;
         prev_ff      <= '0;
         prev_vld_ff  <= 1'b0;
         mpos_ff      <= '0;
         mfill_ff     <= '0;
         apos_ff      <= '0;
         afill_ff     <= '0;
         st_start_ff  <= '0;
         timing_ff    <= 1'b0;
         latch_ff     <= '0;
         latch_vld_ff <= 1'b0;
         win_ff       <= 1'b1;
         next_ms_ff   <= '0;
         next_set_ff  <= 1'b0;
         status_ff    <= ST_CLOSED;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               REG_RAW_OFFSET:  off_ff <= csr_wdata[23:0];
               REG_SCALE:       scale_ff <= csr_wdata;
               REG_GLITCH_JUMP: gj_ff <= csr_wdata[23:0];
               REG_STABLE_BAND: band_ff <= csr_wdata[30:0];
               REG_STABLE_HOLD: hold_ff <= csr_wdata;
               REG_TARE:        tare_ff <= csr_wdata;
               REG_TOLERANCE:   tol_ff <= csr_wdata[30:0];
               REG_WINDOW_IVL: begin
                  ivl_ff      <= csr_wdata;
                  win_ff      <= csr_wdata == 32'd0;
                  next_set_ff <= 1'b0;
               end
               default: ;
            endcase
         end
         case (ctl.state)
            S_FRONT: begin
               if (closed) begin
                  status_ff <= ST_CLOSED;
               end else begin
                  // Reopen the window with fresh filters
                  if (reopen) begin
                     win_ff      <= 1'b1;
                     mpos_ff     <= '0;
                     mfill_ff    <= '0;
                     apos_ff     <= '0;
                     afill_ff    <= '0;
                     timing_ff   <= 1'b0;
                     st_start_ff <= '0;
                  end
                  if (sentinel) begin
                     status_ff <= ST_SENTINEL;
                  end else if (glitch) begin
                     // Resync: restart everything and forget the weight
                     prev_ff      <= raw_ff;
                     prev_vld_ff  <= 1'b0;
                     mpos_ff      <= '0;
                     mfill_ff     <= '0;
                     apos_ff      <= '0;
                     afill_ff     <= '0;
                     timing_ff    <= 1'b0;
                     st_start_ff  <= '0;
                     next_set_ff  <= 1'b0;
                     win_ff       <= !interval;
                     latch_vld_ff <= 1'b0;
                     status_ff    <= ST_GLITCH;
                  end else begin
                     prev_ff     <= raw_ff;
                     prev_vld_ff <= 1'b1;
                     mpos_ff     <= (mpos_eff == MED_LAST) ? 3'd0 : mpos_eff + 3'd1;
                     mfill_ff    <= mfill_new;
                     status_ff   <= ST_FILLING;
                  end
               end
            end
            S_CONV: begin
               apos_ff <= (apos_ff == AW'(AVERAGE_DEPTH - 1)) ? '0 : apos_ff + 1'b1;
               if (afill_ff < FW'(AVERAGE_DEPTH)) afill_ff <= afill_ff + 1'b1;
            end
            S_FIN: begin
               if (stable) begin
                  timing_ff   <= 1'b1;
                  st_start_ff <= start_eff;
                  if (held) begin
                     if (change) begin
                        latch_ff     <= fin_w;
                        latch_vld_ff <= 1'b1;
                     end
                     // Close the window until the next interval
                     if (interval) begin
                        win_ff      <= 1'b0;
                        next_ms_ff  <= now_ff + gap;
                        next_set_ff <= 1'b1;
                     end
                     status_ff <= ST_LATCHED;
                  end else begin
                     status_ff <= ST_HOLDING;
                  end
               end else begin
                  timing_ff <= 1'b0;
                  status_ff <= ST_UNSTABLE;
               end
            end
            default: ;
         endcase
      end
   end

   // Median store: written once per accepted sample
   always_ff @(posedge clock) begin
      if (ctl.state == S_FRONT && !closed && !sentinel && !glitch) begin
         med_ff[mpos_eff] <= raw_ff;
      end
   end

   // Averaging memory: one write and one registered read port
   always_ff @(posedge clock) begin
      if (ctl.state == S_CONV) begin
         avg_mem[apos_ff] <= mg_w;
      end
      rd_ff <= avg_mem[iss_ff[AW-1:0]];
   end

   // Walk control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         rdv_ff <= 1'b0;
      end else begin
         rdv_ff <= (ctl.state == S_WALK) && issue;
      end
   end

   // Per-item work registers
   always_ff @(posedge clock) begin
      case (ctl.state)
         S_IDLE: begin
            if (ev.req_fire) begin
               raw_ff <= req_tdata[23:0];
               now_ff <= req_tdata[55:24];
            end
         end
         S_FRONT: cand_ff <= '0;
         S_MED: begin
            if (is_med) median_ff <= cand_v;
            cand_ff <= cand_ff + 3'd1;
         end
         S_MAG: begin
            cneg_ff <= dconv[24];
            cmag_ff <= dconv[24] ? 25'(-dconv) : 25'(dconv);
         end
         S_MUL0: pacc_ff <= {16'd0, prod};
         S_MUL1: pacc_ff <= pacc_ff + {prod, 16'd0};
         S_CONV: begin
            iss_ff   <= '0;
            first_ff <= 1'b1;
            sum_ff   <= '0;
         end
         S_WALK: begin
            if (issue) iss_ff <= iss_ff + 1'b1;
            if (rdv_ff) begin
               sum_ff   <= sum_ff + SW'(rd_ff);
               first_ff <= 1'b0;
               if (first_ff || rd_ff < mn_ff) mn_ff <= rd_ff;
               if (first_ff || rd_ff > mx_ff) mx_ff <= rd_ff;
            end
         end
         default: ;
      endcase
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (ctl.out_load) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.out_load) begin
         rsp_status_ff <= status_ff;
         rsp_weight_ff <= latch_vld_ff ? latch_ff : 32'd0;
         rsp_has_ff    <= latch_vld_ff;
         rsp_win_ff    <= win_ff;
      end
   end

   assign req_tready = ctl.req_ready;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {6'd0, rsp_win_ff, rsp_has_ff, rsp_weight_ff};

`include "load_cell_weight_filter_defines.svh"

   `LCWF_ASSERT_IMP(a_latched_has_weight, clock, reset, rsp_tvalid && rsp_tuser == ST_LATCHED, rsp_tdata[32], "latched status without stable weight")
   `LCWF_ASSERT_IMP(a_no_weight_zero, clock, reset, rsp_tvalid && !rsp_tdata[32], rsp_tdata[31:0] == 32'd0, "weight shown without stable flag")
   `LCWF_ASSERT_IMP(a_glitch_forgets, clock, reset, rsp_tvalid && rsp_tuser == ST_GLITCH, !rsp_tdata[32], "glitch kept the stable weight")
   `LCWF_ASSERT_IMP(a_fill_bounds, clock, reset, 1'b1, mfill_ff <= MED_SIZE && afill_ff <= FW'(AVERAGE_DEPTH), "filter fill beyond depth")
   `LCWF_ASSERT_NXT(a_div_in_div, clock, reset, ctl.div_start, ctl.state == S_DIV, "divider started outside the walk exit")
endmodule
